FILE: sv/hed_pkg.sv
// Shared types and constants for the HTML entity decoder.
// Used by hed_ctrl, hed_dp and html_entity_decoder; depends on nothing.
package hed_pkg;

	localparam int unsigned MAX_NAME_LEN_DEF = 8;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Known entity names, lower case, zero padded: lt, gt, amp, quot.
	localparam int unsigned NUM_ENT = 4;
	localparam logic [7:0] ENT_NAME [NUM_ENT][4] = '{
		'{8'h6C, 8'h74, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h00, 8'h00},
		'{8'h61, 8'h6D, 8'h70, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74}
	};
	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd2, 3'd2, 3'd3, 3'd4};
	localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h3C, 8'h3E, 8'h26, 8'h22};

	typedef enum logic [1:0] {
		M_PLAIN = 2'd0,
		M_AMP   = 2'd1,
		M_NUM   = 2'd2,
		M_NAME  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_FLUSH  = 2'd1,
		S_EMIT_A = 2'd2,
		S_EMIT_B = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		OSEL_AMP = 2'd0,
		OSEL_BUF = 2'd1,
		OSEL_A   = 2'd2,
		OSEL_B   = 2'd3
	} osel_t;

	typedef struct packed {
		logic  accept;
		logic  load;
		osel_t sel;
		logic  live;
		logic  last;
		logic  adv;
	} cmd_t;

	typedef struct packed {
		logic plan_flush;
		logic plan_a;
		logic plan_b;
		logic a_pend;
		logic b_pend;
		logic flush_end;
		logic out_free;
	} status_t;

endpackage

FILE: sv/hed_ctrl.sv
// Controller of the HTML entity decoder: sequences the result words of one input word.
// Depends on hed_pkg; drives the datapath hed_dp through cmd_t and reads status_t.
module hed_ctrl import hed_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    text_valid,
	output logic    text_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (text_valid && st.out_free) begin
					if (st.plan_flush) begin
						state_n = S_FLUSH;
					end else if (st.plan_a && st.plan_b) begin
						state_n = S_EMIT_B;
					end
				end
			end
			S_FLUSH: begin
				if (st.out_free && st.flush_end) begin
					if (st.a_pend) begin
						state_n = S_EMIT_A;
					end else if (st.b_pend) begin
						state_n = S_EMIT_B;
					end else begin
						state_n = S_IDLE;
					end
				end
			end
			S_EMIT_A: begin
				if (st.out_free) begin
					state_n = st.b_pend ? S_EMIT_B : S_IDLE;
				end
			end
			S_EMIT_B: begin
				if (st.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.sel    = OSEL_AMP;
		text_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				text_stall = !st.out_free;
				if (text_valid && st.out_free) begin
					cmd.accept = 1'b1;
					cmd.live   = 1'b1;
					if (st.plan_flush) begin
						cmd.load = 1'b1;
						cmd.sel  = OSEL_AMP;
					end else if (st.plan_a) begin
						cmd.load = 1'b1;
						cmd.sel  = OSEL_A;
						cmd.last = !st.plan_b;
					end else if (st.plan_b) begin
						cmd.load = 1'b1;
						cmd.sel  = OSEL_B;
						cmd.last = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = OSEL_BUF;
					cmd.adv  = 1'b1;
					cmd.last = st.flush_end && !st.a_pend && !st.b_pend;
				end
			end
			S_EMIT_A: begin
				if (st.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = OSEL_A;
					cmd.last = !st.b_pend;
				end
			end
			S_EMIT_B: begin
				if (st.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = OSEL_B;
					cmd.last = 1'b1;
				end
			end
			default: begin
				text_stall = 1'b1;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A word that is not the final one of its run always leaves more work behind.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.last) |=> (state_q != S_IDLE))
		else $error("non-final result word but controller returned to idle");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && !text_stall) |-> (state_q == S_IDLE && st.out_free))
		else $error("input word taken while a run is still being emitted");
`endif

endmodule

FILE: sv/hed_dp.sv
// Datapath of the HTML entity decoder: scan state, name letters, result plan and output register.
// Depends on hed_pkg; commanded by hed_ctrl through cmd_t, reports through status_t.
module hed_dp import hed_pkg::*; #(
	parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_byte,
	input  logic        text_last,
	input  logic        res_stall,
	input  cmd_t        cmd,
	output status_t     st,
	output logic        res_valid,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	localparam int unsigned CNT_W = $clog2(MAX_NAME_LEN + 1);
	localparam int unsigned IDX_W = $clog2(MAX_NAME_LEN);

	mode_t              mode_q;
	logic [7:0]         accum_q;
	logic [CNT_W-1:0]   count_q;
	logic [NUM_ENT-1:0] match_q;
	logic [7:0]         name_q [MAX_NAME_LEN];
	logic               a_pend_q, b_pend_q;
	logic [7:0]         a_byte_q, b_byte_q;
	logic [CNT_W-1:0]   flush_len_q;
	logic [IDX_W-1:0]   flush_idx_q;
	logic               res_valid_q, run_last_q;
	logic [7:0]         out_byte_q;

	logic               is_letter, is_digit;
	logic [7:0]         folded, acc_digit;
	logic [NUM_ENT-1:0] match_step, ent_hit;
	logic [7:0]         ent_byte;

	logic               flush, a_en, b_en, wr_en;
	logic [7:0]         a_b, b_b;
	logic [CNT_W-1:0]   flen, cnt_n;
	logic [IDX_W-1:0]   widx;
	mode_t              mode_n;
	logic [7:0]         acc_n;
	logic [NUM_ENT-1:0] match_n;
	logic               out_free;
	logic [7:0]         out_sel;

	assign is_letter = (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
	                   (text_byte >= 8'h61 && text_byte <= 8'h7A);
	assign is_digit  = (text_byte >= 8'h30 && text_byte <= 8'h39);
	assign folded    = (text_byte >= 8'h41 && text_byte <= 8'h5A) ?
	                   (text_byte + 8'd32) : text_byte;
	// accum * 10 + digit, kept modulo 256.
	assign acc_digit = {accum_q[4:0], 3'b000} + {accum_q[6:0], 1'b0} +
	                   {4'b0000, text_byte[3:0]};

	// Each candidate name stays alive while every letter so far matches it.
	always_comb begin
		ent_byte = 8'h00;
		for (int k = 0; k < NUM_ENT; k++) begin
			match_step[k] = (count_q == '0 || match_q[k]) && (count_q < CNT_W'(4)) &&
			                (folded == ENT_NAME[k][count_q[1:0]]);
			ent_hit[k]    = match_q[k] && (count_q == CNT_W'(ENT_LEN[k]));
			if (ent_hit[k]) begin
				ent_byte = ENT_CHAR[k];
			end
		end
	end

	// Result plan of the current input word: an optional flush of '&' and the
	// held letters, then an optional word A, then an optional word B.
	always_comb begin
		flush   = 1'b0;
		flen    = count_q;
		a_en    = 1'b0;
		a_b     = accum_q;
		b_en    = 1'b0;
		b_b     = text_byte;
		wr_en   = 1'b0;
		widx    = count_q[IDX_W-1:0];
		mode_n  = mode_q;
		acc_n   = accum_q;
		cnt_n   = count_q;
		match_n = match_q;
		unique case (mode_q)
			M_PLAIN: begin
				b_en = (text_byte != CH_AMP);
				if (text_byte == CH_AMP) begin
					mode_n = M_AMP;
				end
			end
			M_AMP: begin
				if (text_byte == CH_HASH) begin
					acc_n  = 8'h00;
					mode_n = M_NUM;
				end else if (is_letter) begin
					wr_en   = 1'b1;
					widx    = '0;
					cnt_n   = CNT_W'(1);
					match_n = match_step;
					mode_n  = M_NAME;
				end else if (text_byte == CH_SEMI) begin
					mode_n = M_PLAIN;
				end else begin
					a_en   = 1'b1;
					a_b    = CH_AMP;
					mode_n = M_PLAIN;
					b_en   = (text_byte != CH_AMP);
					if (text_byte == CH_AMP) begin
						mode_n = M_AMP;
					end
				end
			end
			M_NUM: begin
				if (is_digit) begin
					acc_n = acc_digit;
				end else begin
					a_en   = (accum_q != 8'h00);
					acc_n  = 8'h00;
					mode_n = M_PLAIN;
					if (text_byte != CH_SEMI) begin
						b_en = (text_byte != CH_AMP);
						if (text_byte == CH_AMP) begin
							mode_n = M_AMP;
						end
					end
				end
			end
			M_NAME: begin
				if (is_letter) begin
					if (count_q < CNT_W'(MAX_NAME_LEN)) begin
						wr_en   = 1'b1;
						cnt_n   = CNT_W'(count_q + 1'b1);
						match_n = match_step;
					end else begin
						flush  = 1'b1;
						a_en   = 1'b1;
						a_b    = text_byte;
						cnt_n  = '0;
						mode_n = M_PLAIN;
					end
				end else if (text_byte == CH_SEMI) begin
					a_en   = |ent_hit;
					a_b    = ent_byte;
					cnt_n  = '0;
					mode_n = M_PLAIN;
				end else begin
					flush  = 1'b1;
					cnt_n  = '0;
					mode_n = M_PLAIN;
					b_en   = (text_byte != CH_AMP);
					if (text_byte == CH_AMP) begin
						mode_n = M_AMP;
					end
				end
			end
			default: mode_n = M_PLAIN;
		endcase

		// End of text drains whatever entity is still pending.
		if (text_last) begin
			case (mode_n)
				M_AMP: begin
					b_en = 1'b1;
					b_b  = CH_AMP;
				end
				M_NUM: begin
					a_en = (acc_n != 8'h00);
					a_b  = acc_n;
				end
				M_NAME: begin
					flush = 1'b1;
					flen  = cnt_n;
				end
				default: begin
				end
			endcase
			mode_n = M_PLAIN;
			acc_n  = 8'h00;
			cnt_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_PLAIN;
			accum_q     <= 8'h00;
			count_q     <= '0;
			match_q     <= '0;
			a_pend_q    <= 1'b0;
			b_pend_q    <= 1'b0;
			flush_len_q <= '0;
			flush_idx_q <= '0;
		end else begin
			if (cmd.accept) begin
				mode_q      <= mode_n;
				accum_q     <= acc_n;
				count_q     <= cnt_n;
				match_q     <= match_n;
				a_pend_q    <= a_en;
				b_pend_q    <= b_en;
				flush_len_q <= flen;
				flush_idx_q <= '0;
			end else if (cmd.adv) begin
				flush_idx_q <= IDX_W'(flush_idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_byte_q <= a_b;
			b_byte_q <= b_b;
			if (wr_en) begin
				name_q[widx] <= text_byte;
			end
		end
	end

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		case (cmd.sel)
			OSEL_AMP: out_sel = CH_AMP;
			OSEL_BUF: out_sel = name_q[flush_idx_q];
			OSEL_A:   out_sel = cmd.live ? a_b : a_byte_q;
			OSEL_B:   out_sel = cmd.live ? b_b : b_byte_q;
			default:  out_sel = CH_AMP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= out_sel;
			run_last_q <= cmd.last;
		end
	end

	assign st.plan_flush = flush;
	assign st.plan_a     = a_en;
	assign st.plan_b     = b_en;
	assign st.a_pend     = a_pend_q;
	assign st.b_pend     = b_pend_q;
	assign st.flush_end  = (CNT_W'(flush_idx_q) + CNT_W'(1)) == flush_len_q;
	assign st.out_free   = out_free;

	assign res_valid = res_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> out_free)
		else $error("output register overwritten while its word is stalled");

	a_count_name: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != M_NAME) |-> (count_q == '0))
		else $error("letters held outside of an entity name");

	a_flush_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv |-> (flush_len_q != '0 && flush_len_q <= CNT_W'(MAX_NAME_LEN)))
		else $error("flush of held letters with an invalid length");
`endif

endmodule

FILE: sv/html_entity_decoder.sv
// HTML entity decoder top level: hed_ctrl sequences, hed_dp holds state and output register.
// The first result word of an input word appears in the cycle after that word is accepted.
// A word with zero or one result frees the input for the next unless the output is stalled;
// more results stall the input until all pass the single output register that reads name letters.
// Reset (arst_n low): plain-text mode, counters and output valid cleared; letters not reset.
module html_entity_decoder import hed_pkg::*; #(
	parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       text_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	cmd_t    cmd;
	status_t st;

	hed_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.st         (st),
		.cmd        (cmd)
	);

	hed_dp #(
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (text_byte),
		.text_last (text_last),
		.res_stall (res_stall),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res_valid),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule
